/* hdl/ssms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_pkg
// Shared types and constants for the sorted set membership search block.
// ----------------------------------------------------------------------------
package ssms_pkg;

    // Field widths of the input and result beats.
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;

    // Operation codes carried in the op field.
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // Outcome of one signed comparison of the key against a stored entry.
    typedef struct packed {
        logic eq;   // key equals entry
        logic lt;   // key is less than entry
    } t_cmp_res;

endpackage

/* hdl/ssms_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_in_if
// Input channel: valid/ready handshake carrying the operation and its value.
// ----------------------------------------------------------------------------
interface ssms_in_if;
    import ssms_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);

endinterface

/* hdl/ssms_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_out_if
// Result channel: valid/ready handshake carrying found, status and count.
// ----------------------------------------------------------------------------
interface ssms_out_if;
    import ssms_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic             status;
    logic [CNT_W-1:0] count;

    modport source (output valid, output found, output status, output count, input ready);
    modport sink   (input valid, input found, input status, input count, output ready);

endinterface

/* hdl/ssms_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_mem
// Value store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssms_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [AW-1:0]                    i_wr_addr,
    input  logic signed [ssms_pkg::VAL_W-1:0] i_wr_data,
    input  logic [AW-1:0]                    i_rd_addr,
    output logic signed [ssms_pkg::VAL_W-1:0] o_rd_data
);
    import ssms_pkg::*;

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data available in the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/ssms_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_cmp
// Shared signed comparator used by both the insertion scan and the search.
// ----------------------------------------------------------------------------
module ssms_cmp (
    input  logic signed [ssms_pkg::VAL_W-1:0] i_key,
    input  logic signed [ssms_pkg::VAL_W-1:0] i_entry,
    output ssms_pkg::t_cmp_res                o_res
);
    import ssms_pkg::*;

    // Equality and signed less-than of the key against the entry.
    always_comb begin
        o_res.eq = (i_key == i_entry);
        o_res.lt = (i_key < i_entry);
    end

endmodule

/* hdl/sorted_set_membership_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_membership_search
// Keeps signed values in ascending order and answers membership queries.
//
//   Channel  Dir  Handshake     Beat contents
//   i_in     in   valid/ready   op (2b), value (32b signed)
//   o_res    out  valid/ready   found (1b), status (1b), count (11b)
//
// Clear, a dropped append, an append or search on an empty store, and an
// unused op go straight to the result. A search runs a binary search of
// at most floor(log2(count)) + 1 probes; one probe per cycle, bound by the
// single memory read port. An append moves each held entry greater than
// the value up one slot, one per cycle, whether some or all of them are
// greater, then writes the value into the slot that is left free.
// Reset clears the state, the count and the output valid; the store itself is not cleared.
// A new beat is taken while an earlier result still waits on o_res.
// ----------------------------------------------------------------------------
module sorted_set_membership_search #(
    parameter int DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssms_in_if.sink     i_in,
    ssms_out_if.source  o_res
);
    import ssms_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              r_state, n_state;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic [AW-1:0]           r_idx, n_idx;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;
    logic [CW-1:0]           r_mid, n_mid;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_found, n_found;
    logic                    r_status, n_status;

    logic                    r_out_valid, n_out_valid;
    logic                    r_out_found, n_out_found;
    logic                    r_out_status, n_out_status;
    logic [CW-1:0]           r_out_count, n_out_count;

    logic                    w_accept;
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic signed [VAL_W-1:0] w_wr_data;
    logic [AW-1:0]           w_rd_addr;
    logic signed [VAL_W-1:0] w_rd_data;
    t_cmp_res                w_cmp;
    logic [CW+CNT_W-1:0]     w_count_ext;

    // Value store.
    ssms_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Shared comparator: the key against the entry just read.
    ssms_cmp u_cmp (
        .i_key   (r_key),
        .i_entry (w_rd_data),
        .o_res   (w_cmp)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    // Sequencer: next state, search bounds, insertion index and store access.
    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_idx     = r_idx;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_count   = r_count;
        n_found   = r_found;
        n_status  = r_status;
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = r_key;
        w_rd_addr = r_mid[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key    = i_in.value;
                    n_found  = 1'b0;
                    n_status = 1'b0;
                    n_state  = S_DONE;
                    if (i_in.op == OP_CLEAR) begin
                        n_count = '0;
                    end else if (i_in.op == OP_APPEND) begin
                        if (r_count >= CW'(DEPTH)) begin
                            n_status = 1'b1;
                        end else if (r_count == '0) begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = '0;
                            w_wr_data = i_in.value;
                            n_count   = r_count + CW'(1);
                        end else begin
                            // Scan down from the top entry.
                            n_idx     = r_count[AW-1:0] - AW'(1);
                            w_rd_addr = n_idx;
                            n_state   = S_INS;
                        end
                    end else if (i_in.op == OP_SEARCH) begin
                        if (r_count != '0) begin
                            n_lo      = '0;
                            n_hi      = r_count;
                            n_mid     = r_count >> 1;
                            w_rd_addr = n_mid[AW-1:0];
                            n_state   = S_SRCH;
                        end
                    end
                end
            end

            S_INS: begin
                if (w_cmp.lt) begin
                    // Entry is greater than the key: move it up one slot.
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_idx + AW'(1);
                    w_wr_data = w_rd_data;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        n_idx     = r_idx - AW'(1);
                        w_rd_addr = n_idx;
                    end
                end else begin
                    // Key goes right after this entry.
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_idx + AW'(1);
                    w_wr_data = r_key;
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end
            end

            S_PUT: begin
                // Every held entry was greater: key lands at the bottom.
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
                w_wr_data = r_key;
                n_count   = r_count + CW'(1);
                n_state   = S_DONE;
            end

            S_SRCH: begin
                if (w_cmp.eq) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else begin
                    if (w_cmp.lt) begin
                        n_hi = r_mid;
                    end else begin
                        n_lo = r_mid + CW'(1);
                    end
                    if (n_lo < n_hi) begin
                        n_mid     = n_lo + ((n_hi - n_lo) >> 1);
                        w_rd_addr = n_mid[AW-1:0];
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: loaded when the result is done and the slot is free.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_DONE && (!r_out_valid || o_res.ready)) begin
            n_out_valid  = 1'b1;
            n_out_found  = r_found;
            n_out_status = r_status;
            n_out_count  = r_count;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_found      <= n_found;
        r_status     <= n_status;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    // The count field keeps its low bits only.
    assign w_count_ext  = {{CNT_W{1'b0}}, r_out_count};
    assign o_res.valid  = r_out_valid;
    assign o_res.found  = r_out_found;
    assign o_res.status = r_out_status;
    assign o_res.count  = w_count_ext[CNT_W-1:0];

endmodule

/* dv/sorted_set_membership_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_membership_search_tb
// Self-checking bench for the sorted set membership search block. A shadow
// copy of the sorted store predicts found, status and count for every beat
// taken on the input channel. Each result beat is checked against the oldest
// prediction. Stimulus runs directed corner beats, a pause until all results
// are back, random mixes of clear, append, search and the unused op on small
// stores, and one fill of the whole store with dropped appends once it is full.
// Both channels idle in short random bursts except in the last random stretch.
// ----------------------------------------------------------------------------
module sorted_set_membership_search_tb;
    import ssms_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int SOFT_FILL_CAP = 96;
    localparam int DRAIN_GUARD = 50000;
    localparam int TAIL_CYCLES = 40;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // One predicted result beat.
    typedef struct packed {
        logic             found;
        logic             status;
        logic [CNT_W-1:0] count;
    } t_membership_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ssms_in_if  in_ch ();
    ssms_out_if res_ch ();

    sorted_set_membership_search #(
        .DEPTH (STORE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    // Shadow of the store contents, kept ascending, and results still owed.
    logic signed [VAL_W-1:0] shadow_set[$];
    t_membership_result      owed_results[$];

    bit idle_on = 1'b1;
    int fail_count = 0;
    int results_seen = 0;
    int clear_beats = 0;
    int append_beats = 0;
    int dropped_appends = 0;
    int search_beats = 0;
    int search_hits = 0;
    int unused_beats = 0;
    int peak_fill = 0;
    int ready_stall_left = 0;

    // Clock: 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Global watchdog.
    initial begin
        #20_000_000;
        $display("sorted_set_membership_search_tb NOT OK");
        $finish;
    end

    // Apply one beat to the shadow store and return the result it should give.
    function automatic t_membership_result predict_result(
        input logic [OP_W-1:0] op,
        input logic signed [VAL_W-1:0] value
    );
        t_membership_result r;
        int lo;
        int hi;
        int mid;
        r = '0;
        case (op)
            OP_CLEAR: begin
                shadow_set.delete();
                clear_beats++;
            end
            OP_APPEND: begin
                append_beats++;
                if (shadow_set.size() >= STORE_DEPTH) begin
                    r.status = 1'b1;
                    dropped_appends++;
                end else begin
                    // Insert after any equal entries.
                    lo = 0;
                    hi = shadow_set.size();
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (shadow_set[mid] <= value) lo = mid + 1;
                        else hi = mid;
                    end
                    shadow_set.insert(lo, value);
                end
            end
            OP_SEARCH: begin
                search_beats++;
                lo = 0;
                hi = shadow_set.size();
                while (lo < hi && !r.found) begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_set[mid] == value) r.found = 1'b1;
                    else if (value < shadow_set[mid]) hi = mid;
                    else lo = mid + 1;
                end
                if (r.found) search_hits++;
            end
            default: begin
                unused_beats++;
            end
        endcase
        if (shadow_set.size() > peak_fill) peak_fill = shadow_set.size();
        r.count = CNT_W'(shadow_set.size());
        return r;
    endfunction

    // Value source: held entries, their neighbors, corner values or noise.
    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        int sel;
        int n;
        sel = $urandom_range(0, 7);
        n = shadow_set.size();
        v = $urandom;
        if (n > 0 && sel < 3) begin
            v = shadow_set[$urandom_range(0, n - 1)];
            if (sel == 2) v = ($urandom_range(0, 1) != 0) ? v + 1 : v - 1;
        end else if (sel < 5) begin
            case ($urandom_range(0, 6))
                0: v = VAL_MIN;
                1: v = VAL_MIN + 1;
                2: v = -1;
                3: v = 0;
                4: v = 1;
                5: v = VAL_MAX - 1;
                default: v = VAL_MAX;
            endcase
        end
        return v;
    endfunction

    // Send one beat; returns at the edge where it was taken.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] value);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        owed_results.push_back(predict_result(op, value));
    endtask

    // Lower valid after the last beat of a stretch.
    task automatic park_input();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // Wait until every owed result is back; anything left is a failure.
    task automatic drain_results();
        int guard;
        guard = 0;
        park_input();
        while (owed_results.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        while (owed_results.size() != 0) begin
            $error("result never arrived: count expected %0d", owed_results[0].count);
            void'(owed_results.pop_front());
            fail_count++;
        end
    endtask

    task automatic send_random_beat();
        int pick;
        pick = $urandom_range(0, 99);
        if (shadow_set.size() >= SOFT_FILL_CAP || pick < 3) begin
            send_beat(OP_CLEAR, $urandom);
        end else if (pick < 6) begin
            send_beat(OP_UNUSED, $urandom);
        end else if (pick < 55) begin
            send_beat(OP_APPEND, pick_value());
        end else begin
            send_beat(OP_SEARCH, pick_value());
        end
    endtask

    // Corner values, every op, empty store and duplicate handling.
    task automatic test_directed_corners();
        send_beat(OP_SEARCH, 0);
        send_beat(OP_SEARCH, VAL_MIN);
        send_beat(OP_UNUSED, 32'shFFFF_FFFF);
        send_beat(OP_APPEND, 0);
        send_beat(OP_APPEND, VAL_MAX);
        send_beat(OP_APPEND, VAL_MIN);
        send_beat(OP_APPEND, -1);
        send_beat(OP_APPEND, 1);
        send_beat(OP_APPEND, 0);
        send_beat(OP_APPEND, VAL_MAX);
        send_beat(OP_SEARCH, VAL_MIN);
        send_beat(OP_SEARCH, VAL_MAX);
        send_beat(OP_SEARCH, 0);
        send_beat(OP_SEARCH, -1);
        send_beat(OP_SEARCH, 5);
        send_beat(OP_SEARCH, VAL_MAX - 1);
        send_beat(OP_SEARCH, VAL_MIN + 1);
        send_beat(OP_UNUSED, 0);
        send_beat(OP_CLEAR, 0);
        send_beat(OP_SEARCH, VAL_MAX);
        send_beat(OP_CLEAR, VAL_MAX);
        send_beat(OP_APPEND, VAL_MIN);
        send_beat(OP_SEARCH, VAL_MIN);
        send_beat(OP_CLEAR, 0);
    endtask

    // Hold the sender until the block has returned everything.
    task automatic test_drain_pause();
        send_beat(OP_APPEND, 7);
        send_beat(OP_APPEND, 3);
        send_beat(OP_APPEND, 5);
        drain_results();
        send_beat(OP_SEARCH, 5);
        send_beat(OP_SEARCH, 4);
        send_beat(OP_CLEAR, 0);
    endtask

    task automatic test_random_mix(input int n_beats);
        repeat (n_beats) send_random_beat();
    endtask

    // Fill the whole store, then hit it with dropped appends, searches and an unused op, then clear it.
    task automatic test_full_store();
        send_beat(OP_CLEAR, 0);
        while (shadow_set.size() < STORE_DEPTH) send_beat(OP_APPEND, pick_value());
        send_beat(OP_APPEND, VAL_MIN);
        send_beat(OP_APPEND, VAL_MAX);
        send_beat(OP_APPEND, $urandom);
        send_beat(OP_SEARCH, shadow_set[0]);
        send_beat(OP_SEARCH, shadow_set[STORE_DEPTH - 1]);
        send_beat(OP_SEARCH, shadow_set[STORE_DEPTH / 2]);
        repeat (12) send_beat(OP_SEARCH, pick_value());
        send_beat(OP_UNUSED, $urandom);
        send_beat(OP_CLEAR, 0);
        send_beat(OP_SEARCH, 0);
    endtask

    // Result sink: ready with short random stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (ready_stall_left > 0) begin
            res_ch.ready <= 1'b0;
            ready_stall_left <= ready_stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            res_ch.ready <= 1'b0;
            ready_stall_left <= $urandom_range(0, 2);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_membership_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                $error("unexpected result beat: found %0b status %0b count %0d",
                       res_ch.found, res_ch.status, res_ch.count);
                fail_count++;
            end else begin
                want = owed_results.pop_front();
                if (res_ch.found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, res_ch.found);
                    fail_count++;
                end
                if (res_ch.status !== want.status) begin
                    $error("status: expected %0b, got %0b", want.status, res_ch.status);
                    fail_count++;
                end
                if (res_ch.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, res_ch.count);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.op     = OP_CLEAR;
        in_ch.value  = '0;
        res_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_drain_pause();
        test_random_mix(130);
        test_full_store();
        // Last stretch runs with both sides always willing.
        idle_on = 1'b0;
        test_random_mix(50);
        drain_results();

        $display("Checked %0d results: %0d clears, %0d appends (%0d dropped when full),",
                 results_seen, clear_beats, append_beats, dropped_appends);
        $display("%0d searches (%0d hits), %0d unused-op beats, peak fill %0d of %0d.",
                 search_beats, search_hits, unused_beats, peak_fill, STORE_DEPTH);
        if (fail_count == 0) begin
            $display("sorted_set_membership_search_tb OK");
        end else begin
            $display("sorted_set_membership_search_tb NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/ssms_pkg.sv
hdl/ssms_in_if.sv
hdl/ssms_out_if.sv
hdl/ssms_mem.sv
hdl/ssms_cmp.sv
hdl/sorted_set_membership_search.sv
dv/sorted_set_membership_search_tb.sv
